### sv/tpa_pkg.sv
package tpa_pkg;

    // default profile size
    localparam int DEF_SLOTS = 8;

    // field widths
    localparam int SAMPLE_W = 56;
    localparam int WEIGHT_W = 8;
    localparam int DIST_W   = 3;
    localparam int SAMPLE_BYTES = 7;

    // register reset values
    localparam logic [2:0] RST_MATCH_THRESHOLD = 3'd2;
    localparam logic [7:0] RST_DISPLACE_LIMIT  = 8'd1;
    localparam logic [7:0] RST_DECAY_FACTOR    = 8'd243;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 8'd255;
    localparam logic [WEIGHT_W-1:0] WEIGHT_NEW = 8'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_MATCH_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_DISPLACE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_DECAY_FACTOR    = 2'd2;

    // operation codes
    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_DECAY      = 1'b1;

    // result action codes
    localparam logic [1:0] ACT_MATCHED  = 2'd0;
    localparam logic [1:0] ACT_INSERTED = 2'd1;
    localparam logic [1:0] ACT_DROPPED  = 2'd2;
    localparam logic [1:0] ACT_DECAYED  = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // sequencer strobes to the datapath
    typedef struct packed {
        logic load;    // input beat taken
        logic scan;    // one slot visited this cycle
        logic first;   // visit of slot zero
        logic commit;  // apply update and load result
    } t_ctrl;

endpackage

### sv/topk_prototype_accumulator_unit.sv
// an input beat is taken in idle, then each slot is visited in turn through a single
// distance compare and decay multiplier, then the update is committed; no new beat is
// taken until the commit is done, and commit waits while an earlier result is still
// unread
// reset (synchronous, active low) empties all slots and loads register defaults
module topk_prototype_accumulator_unit #(
    parameter int SLOTS = tpa_pkg::DEF_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_operation,
    input  logic [7:0] i_channel_r,
    input  logic [7:0] i_channel_g,
    input  logic [7:0] i_channel_b,
    input  logic [7:0] i_channel_a,
    input  logic [6:0] i_tag_byte_low,
    input  logic [6:0] i_tag_byte_high,
    input  logic [4:0] i_direction_code,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_action,
    output logic [2:0] o_slot_index,
    output logic [7:0] o_slot_weight
);
    import tpa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    t_ctrl             ctrl;
    logic [IDX_W-1:0]  idx;
    logic              out_free;

    logic [2:0]        r_match_threshold;
    logic [7:0]        r_displace_limit;
    logic [7:0]        r_decay_factor;

    logic              r_op;
    logic [SAMPLE_W-1:0] r_sample;
    logic [WEIGHT_W-1:0] r_weight [SLOTS];
    logic [SAMPLE_W-1:0] r_slot_sample [SLOTS];

    logic              have_match;
    logic [IDX_W-1:0]  match_idx;
    logic [WEIGHT_W-1:0] match_w;
    logic [IDX_W-1:0]  weak_idx;
    logic [WEIGHT_W-1:0] weak_w;
    logic [WEIGHT_W-1:0] decay_weight;

    logic [WEIGHT_W-1:0] match_new_w;
    logic              do_match;
    logic              do_insert;

    logic              r_out_valid;
    logic [1:0]        r_action, n_action;
    logic [IDX_W+2:0]  n_slot_ext;
    logic [7:0]        r_slot_weight, n_slot_weight;
    logic [2:0]        r_slot_index;

    assign out_free = !r_out_valid || i_out_ready;

    tpa_seq #(.SLOTS(SLOTS)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_in_ready (o_in_ready),
        .o_idx      (idx),
        .o_ctrl     (ctrl)
    );

    tpa_scan_unit #(.SLOTS(SLOTS)) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_idx          (idx),
        .i_weight       (r_weight[idx]),
        .i_slot_sample  (r_slot_sample[idx]),
        .i_sample       (r_sample),
        .i_threshold    (r_match_threshold),
        .i_decay_factor (r_decay_factor),
        .o_have_match   (have_match),
        .o_match_idx    (match_idx),
        .o_match_w      (match_w),
        .o_weak_idx     (weak_idx),
        .o_weak_w       (weak_w),
        .o_decay_weight (decay_weight)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_threshold <= RST_MATCH_THRESHOLD;
            r_displace_limit  <= RST_DISPLACE_LIMIT;
            r_decay_factor    <= RST_DECAY_FACTOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MATCH_THRESHOLD: r_match_threshold <= i_cfg_data[2:0];
                CFG_DISPLACE_LIMIT:  r_displace_limit  <= i_cfg_data;
                CFG_DECAY_FACTOR:    r_decay_factor    <= i_cfg_data;
                default:             ;
            endcase
        end
    end

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_op     <= i_operation;
            r_sample <= {3'b0, i_direction_code, 1'b0, i_tag_byte_high,
                         1'b0, i_tag_byte_low, i_channel_a, i_channel_b,
                         i_channel_g, i_channel_r};
        end
    end

    // update decision
    assign match_new_w = (match_w == WEIGHT_MAX) ? WEIGHT_MAX : match_w + 1'b1;
    assign do_match    = (r_op == OP_ACCUMULATE) && have_match;
    assign do_insert   = (r_op == OP_ACCUMULATE) && !have_match
                         && (weak_w <= r_displace_limit);

    // weight store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_weight[s] <= '0;
            end
        end else if (ctrl.scan && r_op == OP_DECAY) begin
            r_weight[idx] <= decay_weight;
        end else if (ctrl.commit && do_match) begin
            r_weight[match_idx] <= match_new_w;
        end else if (ctrl.commit && do_insert) begin
            r_weight[weak_idx] <= WEIGHT_NEW;
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (ctrl.commit && do_insert) begin
            r_slot_sample[weak_idx] <= r_sample;
        end
    end

    // result fields
    always_comb begin
        n_action      = ACT_DROPPED;
        n_slot_ext    = '0;
        n_slot_weight = '0;
        if (r_op == OP_DECAY) begin
            n_action = ACT_DECAYED;
        end else if (do_match) begin
            n_action      = ACT_MATCHED;
            n_slot_ext    = (IDX_W+3)'(match_idx);
            n_slot_weight = match_new_w;
        end else if (do_insert) begin
            n_action      = ACT_INSERTED;
            n_slot_ext    = (IDX_W+3)'(weak_idx);
            n_slot_weight = WEIGHT_NEW;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.commit) begin
            r_action      <= n_action;
            r_slot_index  <= n_slot_ext[2:0];
            r_slot_weight <= n_slot_weight;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_action;
    assign o_slot_index  = r_slot_index;
    assign o_slot_weight = r_slot_weight;

    // commit only when the output register is free
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.commit |-> out_free)
        else $error("commit over a pending result");

    // a commit always presents a result
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.commit |=> r_out_valid)
        else $error("result lost after commit");

    // an inserted slot always carries weight one
    a_insert_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_action == ACT_INSERTED) |-> r_slot_weight == WEIGHT_NEW)
        else $error("inserted slot weight wrong");

endmodule

### sv/tpa_scan_unit.sv
module tpa_scan_unit #(
    parameter int SLOTS = tpa_pkg::DEF_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tpa_pkg::t_ctrl                i_ctrl,
    input  logic [$clog2(SLOTS)-1:0]      i_idx,
    input  logic [tpa_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic [tpa_pkg::SAMPLE_W-1:0]  i_slot_sample,
    input  logic [tpa_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [2:0]                    i_threshold,
    input  logic [7:0]                    i_decay_factor,
    output logic                          o_have_match,
    output logic [$clog2(SLOTS)-1:0]      o_match_idx,
    output logic [tpa_pkg::WEIGHT_W-1:0]  o_match_w,
    output logic [$clog2(SLOTS)-1:0]      o_weak_idx,
    output logic [tpa_pkg::WEIGHT_W-1:0]  o_weak_w,
    output logic [tpa_pkg::WEIGHT_W-1:0]  o_decay_weight
);
    import tpa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic              r_have_match, n_have_match;
    logic [IDX_W-1:0]  r_match_idx, n_match_idx;
    logic [DIST_W-1:0] r_match_dist, n_match_dist;
    logic [WEIGHT_W-1:0] r_match_w, n_match_w;
    logic [IDX_W-1:0]  r_weak_idx, n_weak_idx;
    logic [WEIGHT_W-1:0] r_weak_w, n_weak_w;

    logic [DIST_W-1:0] byte_diff;
    logic [15:0]       product;
    logic              cur_have;
    logic [IDX_W-1:0]  cur_weak_idx;
    logic [WEIGHT_W-1:0] cur_weak_w;

    // count of differing byte positions
    always_comb begin
        byte_diff = '0;
        for (int k = 0; k < SAMPLE_BYTES; k++) begin
            byte_diff = byte_diff + DIST_W'(i_slot_sample[8*k +: 8] != i_sample[8*k +: 8]);
        end
    end

    // shared decay multiplier, result registered into the weight store
    assign product        = 16'(i_weight) * 16'(i_decay_factor);
    assign o_decay_weight = product[15:8];

    // running best match and weakest slot
    always_comb begin
        cur_have     = i_ctrl.first ? 1'b0 : r_have_match;
        cur_weak_idx = i_ctrl.first ? '0 : r_weak_idx;
        cur_weak_w   = i_ctrl.first ? i_weight : r_weak_w;
        n_have_match = cur_have;
        n_match_idx  = r_match_idx;
        n_match_dist = r_match_dist;
        n_match_w    = r_match_w;
        n_weak_idx   = cur_weak_idx;
        n_weak_w     = cur_weak_w;
        if (i_weight == '0) begin
            n_weak_idx = i_idx;
            n_weak_w   = '0;
        end else begin
            if ((byte_diff <= i_threshold) && (!cur_have || (byte_diff < r_match_dist))) begin
                n_have_match = 1'b1;
                n_match_idx  = i_idx;
                n_match_dist = byte_diff;
                n_match_w    = i_weight;
            end
            if (i_weight < cur_weak_w) begin
                n_weak_idx = i_idx;
                n_weak_w   = i_weight;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_match <= 1'b0;
        end else if (i_ctrl.scan) begin
            r_have_match <= n_have_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan) begin
            r_match_idx  <= n_match_idx;
            r_match_dist <= n_match_dist;
            r_match_w    <= n_match_w;
            r_weak_idx   <= n_weak_idx;
            r_weak_w     <= n_weak_w;
        end
    end

    assign o_have_match = r_have_match;
    assign o_match_idx  = r_match_idx;
    assign o_match_w    = r_match_w;
    assign o_weak_idx   = r_weak_idx;
    assign o_weak_w     = r_weak_w;

    // a match always lies within the threshold
    a_match_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_match |-> (r_match_dist <= i_threshold || $past(i_ctrl.commit)
                          || !$past(i_ctrl.scan)))
        else $error("match distance above threshold");

    // a matched slot is never an empty one
    a_match_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_match |-> r_match_w != '0)
        else $error("match recorded on empty slot");

endmodule

### sv/tpa_seq.sv
module tpa_seq #(
    parameter int SLOTS = tpa_pkg::DEF_SLOTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_out_free,
    output logic                     o_in_ready,
    output logic [$clog2(SLOTS)-1:0] o_idx,
    output tpa_pkg::t_ctrl           o_ctrl
);
    import tpa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             last;

    assign last = (r_idx == LAST_IDX);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (last) n_state = ST_COMMIT;
            ST_COMMIT: if (i_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_ctrl        = '0;
        n_idx         = r_idx;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
                n_idx       = '0;
            end
            ST_SCAN: begin
                o_ctrl.scan  = 1'b1;
                o_ctrl.first = (r_idx == '0);
                n_idx        = last ? '0 : r_idx + 1'b1;
            end
            ST_COMMIT: begin
                o_ctrl.commit = i_out_free;
                n_idx         = '0;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_idx = r_idx;

    // slot counter rests at zero outside the scan
    a_idx_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_SCAN |-> r_idx == '0)
        else $error("slot counter not at rest");

    // a taken beat starts a scan
    a_load_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> r_state == ST_SCAN)
        else $error("scan did not start");

    // the last slot hands over to commit
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && last) |=> r_state == ST_COMMIT)
        else $error("scan did not end");

endmodule
